/* rtl/core/seen_address_detector_defines.svh */
// ----------------------------------------------------------------------------
// Seen address detector assertion macros
// Shared property wrappers, clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEEN_ADDRESS_DETECTOR_DEFINES_SVH
`define SEEN_ADDRESS_DETECTOR_DEFINES_SVH

// Require cons in the same cycle as ante
`define SAD_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Require cons in the cycle after ante
`define SAD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Require expr to stay low
`define SAD_ASSERT_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

/* rtl/core/sad_pkg.sv */
// ----------------------------------------------------------------------------
// Seen address detector package
// Item and result types, fixed widths and the table engine state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package sad_pkg;

	localparam int ADDR_W  = 32;
	// Bucket index is reduced one address nibble per front stage
	localparam int DIGIT_W = 4;
	localparam int DIGITS  = ADDR_W / DIGIT_W;
	// Walk generation tag kept with each bucket row
	localparam int EPOCH_W = 8;

	typedef struct packed {
		logic [ADDR_W-1:0] node_address;
		logic              new_walk;
	} sad_in_t;

	typedef struct packed {
		logic seen_before;
		logic table_full;
	} sad_out_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_READ,
		ST_EVAL
	} sad_back_state_t;

endpackage

`default_nettype wire

/* rtl/core/sad_front.sv */
// ----------------------------------------------------------------------------
// Seen address detector front end
// Accepts items and computes the bucket index (address mod BUCKETS), one
// address nibble per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sad_front #(
	parameter int BUCKETS = 11,
	parameter int BW      = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire sad_pkg::sad_in_t item,
	output logic                 full,
	input  wire logic            q_full,
	output logic                 q_push,
	output sad_pkg::sad_in_t     q_item,
	output logic [BW-1:0]        q_bucket
);
	import sad_pkg::*;

	localparam int XW = BW + DIGIT_W;

	// Shift in one nibble and bring the remainder back below BUCKETS
	function automatic logic [BW-1:0] mod_step(input logic [BW-1:0] r,
	                                           input logic [DIGIT_W-1:0] d);
		logic [XW-1:0] x;
		x = {r, d};
		for (int j = DIGIT_W - 1; j >= 0; j--) begin
			if (x >= (XW'(BUCKETS) << j)) begin
				x = x - (XW'(BUCKETS) << j);
			end
		end
		return x[BW-1:0];
	endfunction

	logic [DIGITS-1:0] vld_s;
	logic [BW-1:0]     rem_s  [DIGITS];
	sad_in_t           item_s [DIGITS];
	logic              adv;

	// Advance all stages together unless the last one is blocked
	assign adv      = !(vld_s[DIGITS-1] && q_full);
	assign full     = !adv;
	assign q_push   = vld_s[DIGITS-1] && !q_full;
	assign q_item   = item_s[DIGITS-1];
	assign q_bucket = rem_s[DIGITS-1];

	for (genvar k = 0; k < DIGITS; k++) begin : g_stage
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (adv) begin
					vld_s[k] <= push;
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					item_s[k] <= item;
					rem_s[k]  <= mod_step('0,
						item.node_address[ADDR_W-1 -: DIGIT_W]);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (adv) begin
					vld_s[k] <= vld_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					item_s[k] <= item_s[k-1];
					rem_s[k]  <= mod_step(rem_s[k-1],
						item_s[k-1].node_address[ADDR_W-1-k*DIGIT_W -: DIGIT_W]);
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sad_queue.sv */
// ----------------------------------------------------------------------------
// Seen address detector decoupling queue
// Two-entry queue between the bucket front end and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sad_queue #(
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      pop_data,
	output logic                   empty
);
	logic [DATA_W-1:0] entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sad_back.sv */
// ----------------------------------------------------------------------------
// Seen address detector table engine
// Reads the bucket row, matches the address against its ways, stores a new
// address in the lowest free way and writes the row back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "seen_address_detector_defines.svh"

module sad_back #(
	parameter int BUCKETS = 11,
	parameter int WAYS    = 4,
	parameter int BW      = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_empty,
	input  wire sad_pkg::sad_in_t q_item,
	input  wire logic [BW-1:0]    q_bucket,
	output logic                  q_pop,
	input  wire logic             pop,
	output logic                  empty,
	output sad_pkg::sad_out_t     result
);
	import sad_pkg::*;

	// Bucket rows: way tags, way valid mask, walk generation
	logic [WAYS*ADDR_W-1:0] tag_mem   [BUCKETS];
	logic [WAYS-1:0]        vmask_mem [BUCKETS];
	logic [EPOCH_W-1:0]     epoch_mem [BUCKETS];

	logic [WAYS*ADDR_W-1:0] rd_tags_q;
	logic [WAYS-1:0]        rd_vmask_q;
	logic [EPOCH_W-1:0]     rd_epoch_q;

	sad_back_state_t state_q, state_n;
	logic [BW-1:0]      sweep_idx_q, sweep_idx_n;
	logic               sweep_item_q, sweep_item_n;
	logic [EPOCH_W-1:0] epoch_q, epoch_n;
	logic [ADDR_W-1:0]  item_addr_q;
	logic [BW-1:0]      item_bucket_q;
	logic               out_valid_q;
	sad_out_t           out_q;

	logic                   take;
	logic                   rd_en;
	logic [BW-1:0]          rd_addr;
	logic                   we;
	logic [BW-1:0]          waddr;
	logic [WAYS*ADDR_W-1:0] wtags;
	logic [WAYS-1:0]        wvmask;
	logic [EPOCH_W-1:0]     wepoch;
	logic                   out_load;

	logic [WAYS-1:0] eff_valid;
	logic [WAYS-1:0] match;
	logic [WAYS-1:0] free_ways;
	logic [WAYS-1:0] store_mask;
	logic            hit;
	logic            full_flag;
	logic [WAYS*ADDR_W-1:0] new_tags;

	assign empty  = !out_valid_q;
	assign result = out_q;
	assign take   = (state_q == ST_IDLE) && !q_empty && (!out_valid_q || pop);

	// Match and pick the lowest free way of the row just read
	always_comb begin
		eff_valid = (rd_epoch_q == epoch_q) ? rd_vmask_q : '0;
		for (int w = 0; w < WAYS; w++) begin
			match[w] = eff_valid[w] && (rd_tags_q[w*ADDR_W +: ADDR_W] == item_addr_q);
		end
		hit        = |match;
		free_ways  = ~eff_valid;
		store_mask = hit ? '0 : (free_ways & (~free_ways + WAYS'(1)));
		full_flag  = !hit && (free_ways == '0);
		for (int w = 0; w < WAYS; w++) begin
			new_tags[w*ADDR_W +: ADDR_W] = store_mask[w] ? item_addr_q
				: rd_tags_q[w*ADDR_W +: ADDR_W];
		end
	end

	// Sequence sweep, read and evaluate steps
	always_comb begin
		state_n      = state_q;
		sweep_idx_n  = sweep_idx_q;
		sweep_item_n = sweep_item_q;
		epoch_n      = epoch_q;
		q_pop        = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = item_bucket_q;
		we           = 1'b0;
		waddr        = item_bucket_q;
		wtags        = new_tags;
		wvmask       = eff_valid | store_mask;
		wepoch       = epoch_q;
		out_load     = 1'b0;
		unique case (state_q)
			ST_SWEEP: begin
				we     = 1'b1;
				waddr  = sweep_idx_q;
				wtags  = '0;
				wvmask = '0;
				wepoch = '0;
				if (sweep_idx_q == BW'(BUCKETS - 1)) begin
					state_n = sweep_item_q ? ST_READ : ST_IDLE;
				end else begin
					sweep_idx_n = sweep_idx_q + BW'(1);
				end
			end
			ST_IDLE: begin
				if (take) begin
					q_pop = 1'b1;
					if (q_item.new_walk && (epoch_q == '1)) begin
						// Generation wraps: clear every row first
						state_n      = ST_SWEEP;
						sweep_idx_n  = '0;
						sweep_item_n = 1'b1;
						epoch_n      = '0;
					end else begin
						rd_en   = 1'b1;
						rd_addr = q_bucket;
						epoch_n = epoch_q + EPOCH_W'(q_item.new_walk);
						state_n = ST_EVAL;
					end
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_n = ST_EVAL;
			end
			ST_EVAL: begin
				we       = 1'b1;
				out_load = 1'b1;
				state_n  = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_idx_q  <= '0;
			sweep_item_q <= 1'b0;
			epoch_q      <= '0;
		end else begin
			state_q      <= state_n;
			sweep_idx_q  <= sweep_idx_n;
			sweep_item_q <= sweep_item_n;
			epoch_q      <= epoch_n;
		end
	end

	// Capture the item taken from the queue
	always_ff @(posedge clk) begin
		if (take) begin
			item_addr_q   <= q_item.node_address;
			item_bucket_q <= q_bucket;
		end
	end

	// Bucket memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			tag_mem[waddr]   <= wtags;
			vmask_mem[waddr] <= wvmask;
			epoch_mem[waddr] <= wepoch;
		end
		if (rd_en) begin
			rd_tags_q  <= tag_mem[rd_addr];
			rd_vmask_q <= vmask_mem[rd_addr];
			rd_epoch_q <= epoch_mem[rd_addr];
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.seen_before <= hit;
			out_q.table_full  <= full_flag;
		end
	end

	`SAD_ASSERT_IMPL(a_eval_slot_free, state_q == ST_EVAL, !out_valid_q, "result slot busy at evaluation")
	`SAD_ASSERT_NEXT(a_eval_gives_result, state_q == ST_EVAL, out_valid_q && (state_q == ST_IDLE), "evaluation gave no result")
	`SAD_ASSERT_IMPL(a_read_after_sweep, state_q == ST_READ, $past(state_q) == ST_SWEEP, "held read without a sweep")
	`SAD_ASSERT_NEVER(a_store_conflict, (state_q == ST_EVAL) && (!$onehot0(store_mask) || (hit && full_flag)), "store mask or flags inconsistent")

endmodule

`default_nettype wire

/* rtl/core/seen_address_detector.sv */
// ----------------------------------------------------------------------------
// Seen address detector
// Flags addresses repeated within one walk using a bucketed hash set.
// ----------------------------------------------------------------------------
// An item can enter every cycle in which full is low into an eight-stage front
// pipeline that reduces the address to its bucket (address mod BUCKETS), then
// waits in a two-entry queue for the table engine. The engine works on one
// item at a time: it first reads the bucket row, then compares the WAYS tags
// and writes the row back, and it never reads and writes the bucket memory
// in the same cycle. new_walk empties the set by stepping an eight-bit walk
// generation kept with each row. After reset, and on every 256th new walk,
// a clearing pass runs through every row of the bucket memory during which
// the engine takes no item.
// ----------------------------------------------------------------------------
`default_nettype none

module seen_address_detector #(
	parameter int BUCKETS = 11,
	parameter int WAYS    = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire sad_pkg::sad_in_t item,
	output logic                  full,
	output logic                  empty,
	input  wire logic             pop,
	output sad_pkg::sad_out_t     result
);
	import sad_pkg::*;

	localparam int BW     = $clog2(BUCKETS);
	localparam int QD_W   = $bits(sad_in_t) + BW;

	logic              fq_push;
	logic              fq_full;
	sad_in_t           fq_item;
	logic [BW-1:0]     fq_bucket;
	logic              qb_pop;
	logic              qb_empty;
	logic [QD_W-1:0]   qb_data;
	sad_in_t           qb_item;
	logic [BW-1:0]     qb_bucket;

	// Reduce addresses to buckets
	sad_front #(
		.BUCKETS (BUCKETS),
		.BW      (BW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.q_full   (fq_full),
		.q_push   (fq_push),
		.q_item   (fq_item),
		.q_bucket (fq_bucket)
	);

	// Decouple the front end from the table engine
	sad_queue #(
		.DATA_W (QD_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fq_push),
		.push_data ({fq_item, fq_bucket}),
		.full      (fq_full),
		.pop       (qb_pop),
		.pop_data  (qb_data),
		.empty     (qb_empty)
	);

	assign qb_item   = qb_data[QD_W-1:BW];
	assign qb_bucket = qb_data[BW-1:0];

	// Look up and update the seen set
	sad_back #(
		.BUCKETS (BUCKETS),
		.WAYS    (WAYS),
		.BW      (BW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (qb_empty),
		.q_item   (qb_item),
		.q_bucket (qb_bucket),
		.q_pop    (qb_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

`default_nettype wire
